// ===== rtl/core/vra_pkg.sv =====
// ============================================================================
// vra_pkg
// Shared types, constants and tables of the vector rotation core.
// ============================================================================
package vra_pkg;

    // Sine/cosine pipeline depth.
    localparam int TRIG_ITERATIONS = 24;
    localparam int CORDIC_STEPS    = (TRIG_ITERATIONS < 32) ? TRIG_ITERATIONS : 32;
    localparam int CORDIC_LAT      = CORDIC_STEPS + 4;

    // Axis normalization: prep stages, root bits, divider load, quotient bits, final stage.
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 32;
    localparam int AXIS_LAT   = 6 + SQRT_STEPS + 1 + DIV_STEPS + 1;

    // Matrix build and vector product stages after the axis is ready.
    localparam int PIPE_LAT = AXIS_LAT + 5;
    localparam int TRIG_PAD = AXIS_LAT - CORDIC_LAT;

    // Angle constants, wide Q6.30 form for the modulo and narrow Q4.30 form after it.
    localparam logic signed [35:0] TWO_PI_W     = 36'sd6746518852;
    localparam logic signed [35:0] NEG_TWO_PI_W = -36'sd6746518852;
    localparam logic signed [35:0] PI_W         = 36'sd3373259426;
    localparam logic signed [35:0] NEG_PI_W     = -36'sd3373259426;
    localparam logic signed [33:0] PI_Z         = 34'sd3373259426;
    localparam logic signed [33:0] HALF_PI_Z    = 34'sd1686629713;
    localparam logic signed [33:0] NEG_HALF_PI_Z = -34'sd1686629713;
    localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;

    localparam logic signed [34:0] Q30_ONE_T = 35'sd1073741824;
    localparam logic signed [35:0] Q30_ONE_M = 36'sd1073741824;
    localparam logic signed [35:0] Q30_NEG_ONE_M = -36'sd1073741824;
    localparam logic [31:0]        Q30_ONE_U = 32'd1073741824;

    typedef logic signed [33:0] trig_t;
    typedef logic signed [31:0] unit_t;

    function automatic logic [31:0] atan_q30(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'h3243F6A8;
            5'd1:    v = 32'h1DAC6705;
            5'd2:    v = 32'h0FADBAFC;
            5'd3:    v = 32'h07F56EA6;
            5'd4:    v = 32'h03FEAB76;
            5'd5:    v = 32'h01FFD55B;
            5'd6:    v = 32'h00FFFAAA;
            5'd7:    v = 32'h007FFF55;
            5'd8:    v = 32'h003FFFEA;
            5'd9:    v = 32'h001FFFFD;
            5'd10:   v = 32'h000FFFFF;
            5'd11:   v = 32'h0007FFFF;
            5'd12:   v = 32'h0003FFFF;
            5'd13:   v = 32'h0001FFFF;
            5'd14:   v = 32'h0000FFFF;
            5'd15:   v = 32'h00007FFF;
            5'd16:   v = 32'h00003FFF;
            5'd17:   v = 32'h00001FFF;
            5'd18:   v = 32'h00000FFF;
            5'd19:   v = 32'h000007FF;
            5'd20:   v = 32'h000003FF;
            5'd21:   v = 32'h000001FF;
            5'd22:   v = 32'h000000FF;
            5'd23:   v = 32'h0000007F;
            5'd24:   v = 32'h0000003F;
            5'd25:   v = 32'h0000001F;
            5'd26:   v = 32'h0000000F;
            5'd27:   v = 32'h00000008;
            5'd28:   v = 32'h00000004;
            5'd29:   v = 32'h00000002;
            5'd30:   v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // Round a Q30 product: add one half and shift right by 30 with floor.
    function automatic logic signed [37:0] rnd30(input logic signed [67:0] p);
        logic signed [67:0] t;
        t = (p + 68'sd536870912) >>> 30;
        return t[37:0];
    endfunction

endpackage

// ===== rtl/core/vra_cordic.sv =====
// ============================================================================
// vra_cordic
// Angle reduction into (-pi, pi], quadrant fold and a rotation-mode CORDIC
// with one iteration per stage, giving cosine and sine in Q4.30.
// ============================================================================
module vra_cordic
    import vra_pkg::*;
(
    input  logic               aclk,
    input  logic               en,
    input  logic signed [31:0] angle,
    output trig_t              cos_q30,
    output trig_t              sin_q30
);

    logic signed [35:0] r4;
    logic signed [35:0] r1_next;
    logic signed [35:0] r1_reg;
    logic signed [35:0] r3_wide;
    logic signed [33:0] r3_reg;
    trig_t              x_reg [0:CORDIC_STEPS];
    trig_t              y_reg [0:CORDIC_STEPS];
    trig_t              z_reg [0:CORDIC_STEPS];
    logic               flip_reg [0:CORDIC_STEPS];
    trig_t              cos_reg;
    trig_t              sin_reg;

    assign r4 = {{2{angle[31]}}, angle, 2'b00};

    // Truncating remainder by two pi; the widened angle is below twice that.
    always_comb begin
        if (r4 >= TWO_PI_W) begin
            r1_next = r4 - TWO_PI_W;
        end else if (r4 <= NEG_TWO_PI_W) begin
            r1_next = r4 + TWO_PI_W;
        end else begin
            r1_next = r4;
        end
        if (r1_reg > PI_W) begin
            r3_wide = r1_reg - TWO_PI_W;
        end else if (r1_reg <= NEG_PI_W) begin
            r3_wide = r1_reg + TWO_PI_W;
        end else begin
            r3_wide = r1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r1_reg <= r1_next;
            r3_reg <= r3_wide[33:0];
            x_reg[0] <= CORDIC_GAIN;
            y_reg[0] <= '0;
            if (r3_reg > HALF_PI_Z) begin
                z_reg[0]    <= r3_reg - PI_Z;
                flip_reg[0] <= 1'b1;
            end else if (r3_reg < NEG_HALF_PI_Z) begin
                z_reg[0]    <= r3_reg + PI_Z;
                flip_reg[0] <= 1'b1;
            end else begin
                z_reg[0]    <= r3_reg;
                flip_reg[0] <= 1'b0;
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        always_ff @(posedge aclk) begin
            if (en) begin
                flip_reg[i+1] <= flip_reg[i];
                if (!z_reg[i][33]) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - signed'(34'(atan_q30(5'(i))));
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + signed'(34'(atan_q30(5'(i))));
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_reg <= flip_reg[CORDIC_STEPS] ? -x_reg[CORDIC_STEPS] : x_reg[CORDIC_STEPS];
            sin_reg <= flip_reg[CORDIC_STEPS] ? -y_reg[CORDIC_STEPS] : y_reg[CORDIC_STEPS];
        end
    end

    assign cos_q30 = cos_reg;
    assign sin_q30 = sin_reg;

endmodule

// ===== rtl/core/vra_axis.sv =====
// ============================================================================
// vra_axis
// Axis normalization: magnitude prescale, pipelined integer square root
// (one root bit per stage) and three pipelined restoring dividers (one
// quotient bit per stage), giving the unit axis in Q2.30.
// ============================================================================
module vra_axis
    import vra_pkg::*;
(
    input  logic               aclk,
    input  logic               en,
    input  logic signed [31:0] axis_x,
    input  logic signed [31:0] axis_y,
    input  logic signed [31:0] axis_z,
    output unit_t              u_x,
    output unit_t              u_y,
    output unit_t              u_z
);

    localparam int SQ0 = 6;
    localparam int SQN = SQ0 + SQRT_STEPS;
    localparam int DV0 = SQN + 1;
    localparam int DVN = DV0 + DIV_STEPS;

    logic signed [31:0] a [0:2];
    logic [2:0]  sgn_reg  [1:DVN];
    logic        zero_reg [3:DVN];
    logic [31:0] mag_reg  [0:2][1:SQN];
    logic [31:0] max_reg;
    logic [4:0]  sh_reg;
    logic [63:0] sq_reg   [0:2];
    logic [63:0] sqn_reg  [SQ0:SQN];
    logic [33:0] rem_reg  [SQ0:SQN];
    logic [31:0] root_reg [SQ0:SQN];
    logic [31:0] dlen_reg [DV0:DVN];
    logic [61:0] dnum_reg [0:2][DV0:DVN];
    logic [31:0] drem_reg [0:2][DV0:DVN];
    logic [31:0] dq_reg   [0:2][DV0:DVN];
    unit_t       u_reg    [0:2];

    // Left shift that brings the largest magnitude to at least 2^30.
    function automatic logic [4:0] lead_shift(input logic [31:0] m);
        logic [4:0] p;
        p = '0;
        for (int i = 0; i < 32; i++) begin
            if (m[i]) begin
                p = 5'(i);
            end
        end
        return (p >= 5'd30) ? 5'd0 : 5'd30 - p;
    endfunction

    assign a[0] = axis_x;
    assign a[1] = axis_y;
    assign a[2] = axis_z;

    always_ff @(posedge aclk) begin
        if (en) begin
            sgn_reg[1] <= {axis_z[31], axis_y[31], axis_x[31]};
            max_reg    <= (mag_reg[0][1] > mag_reg[1][1])
                          ? ((mag_reg[0][1] > mag_reg[2][1]) ? mag_reg[0][1] : mag_reg[2][1])
                          : ((mag_reg[1][1] > mag_reg[2][1]) ? mag_reg[1][1] : mag_reg[2][1]);
            sh_reg      <= lead_shift(max_reg);
            zero_reg[3] <= (max_reg == '0);
            sqn_reg[SQ0]  <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            rem_reg[SQ0]  <= '0;
            root_reg[SQ0] <= '0;
            dlen_reg[DV0] <= root_reg[SQN];
        end
    end

    for (genvar s = 2; s <= DVN; s++) begin : g_sgn
        always_ff @(posedge aclk) begin
            if (en) begin
                sgn_reg[s] <= sgn_reg[s-1];
            end
        end
    end

    for (genvar s = 4; s <= DVN; s++) begin : g_zero
        always_ff @(posedge aclk) begin
            if (en) begin
                zero_reg[s] <= zero_reg[s-1];
            end
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_comp
        always_ff @(posedge aclk) begin
            if (en) begin
                mag_reg[k][1] <= a[k][31] ? 32'(-a[k]) : 32'(a[k]);
                mag_reg[k][2] <= mag_reg[k][1];
                mag_reg[k][3] <= mag_reg[k][2];
                mag_reg[k][4] <= mag_reg[k][3] << sh_reg;
                sq_reg[k]     <= 64'(mag_reg[k][4]) * 64'(mag_reg[k][4]);
                dnum_reg[k][DV0] <= {mag_reg[k][SQN], 30'b0} + 62'(root_reg[SQN] >> 1);
                drem_reg[k][DV0] <= '0;
                dq_reg[k][DV0]   <= '0;
            end
        end

        for (genvar s = 5; s <= SQN; s++) begin : g_mag
            always_ff @(posedge aclk) begin
                if (en) begin
                    mag_reg[k][s] <= mag_reg[k][s-1];
                end
            end
        end

        // The quotient fits 32 bits, so the top 30 numerator bits start the remainder.
        for (genvar s = DV0 + 1; s <= DVN; s++) begin : g_div
            localparam int J = DVN - s;
            logic [32:0] cur;
            assign cur = (s == DV0 + 1)
                         ? {2'b00, dnum_reg[k][s-1][61:32], dnum_reg[k][s-1][J]}
                         : {drem_reg[k][s-1], dnum_reg[k][s-1][J]};
            always_ff @(posedge aclk) begin
                if (en) begin
                    dnum_reg[k][s] <= dnum_reg[k][s-1];
                    if (cur >= {1'b0, dlen_reg[s-1]}) begin
                        drem_reg[k][s] <= 32'(cur - {1'b0, dlen_reg[s-1]});
                        dq_reg[k][s]   <= {dq_reg[k][s-1][30:0], 1'b1};
                    end else begin
                        drem_reg[k][s] <= cur[31:0];
                        dq_reg[k][s]   <= {dq_reg[k][s-1][30:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                if (zero_reg[DVN]) begin
                    u_reg[k] <= '0;
                end else if (dq_reg[k][DVN] > Q30_ONE_U) begin
                    u_reg[k] <= sgn_reg[DVN][k] ? -unit_t'(Q30_ONE_U) : unit_t'(Q30_ONE_U);
                end else begin
                    u_reg[k] <= sgn_reg[DVN][k] ? -unit_t'(dq_reg[k][DVN])
                                                : unit_t'(dq_reg[k][DVN]);
                end
            end
        end
    end

    for (genvar s = DV0 + 1; s <= DVN; s++) begin : g_len
        always_ff @(posedge aclk) begin
            if (en) begin
                dlen_reg[s] <= dlen_reg[s-1];
            end
        end
    end

    // Square root, two radicand bits per stage, most significant pair first.
    for (genvar s = SQ0 + 1; s <= SQN; s++) begin : g_sqrt
        localparam int B = SQN - s;
        logic [34:0] cur;
        logic [34:0] trial;
        assign cur   = {rem_reg[s-1][32:0], sqn_reg[s-1][2*B+1 -: 2]};
        assign trial = {1'b0, root_reg[s-1], 2'b01};
        always_ff @(posedge aclk) begin
            if (en) begin
                sqn_reg[s] <= sqn_reg[s-1];
                if (cur >= trial) begin
                    rem_reg[s]  <= 34'(cur - trial);
                    root_reg[s] <= {root_reg[s-1][30:0], 1'b1};
                end else begin
                    rem_reg[s]  <= cur[33:0];
                    root_reg[s] <= {root_reg[s-1][30:0], 1'b0};
                end
            end
        end
    end

    assign u_x = u_reg[0];
    assign u_y = u_reg[1];
    assign u_z = u_reg[2];

endmodule

// ===== rtl/core/vector_rotate_arbitrary_axis_core.sv =====
// ============================================================================
// vector_rotate_arbitrary_axis_core
// Rotates a 3D vector about an arbitrary axis with the Rodrigues matrix.
//
//   Channel  Direction  Payload (lowest bits first)
//   s_axis   in         tdata: vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle
//   m_axis   out        tdata: rot_x, rot_y, rot_z; tuser: saturated
//
// One beat is accepted per cycle while the output is not stalled; the pipeline
// depth is set by the axis path (32 square root stages and 32 divider stages).
// Reset clears only the stage valid bits; no clearing pass is needed.
// A stalled output holds the whole pipeline in place, so nothing is lost.
// ============================================================================
module vector_rotate_arbitrary_axis_core
    import vra_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // vec_x, vec_y, vec_z, axis_x, axis_y, axis_z, angle (32 bits each)
    input  logic [223:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // rot_x, rot_y, rot_z (32 bits each)
    output logic [95:0]  m_axis_tdata,
    // saturated
    output logic [0:0]   m_axis_tuser
);

    localparam int ST_U  = AXIS_LAT;
    localparam int ST_M1 = ST_U + 1;
    localparam int ST_M2 = ST_U + 2;
    localparam int ST_M3 = ST_U + 3;
    localparam int ST_M4 = ST_U + 4;

    logic               adv;
    logic [PIPE_LAT:1]  vld_reg;
    logic [95:0]        vd_reg [1:ST_M4];
    logic               za_reg [1:ST_M4];
    trig_t              cos_c;
    trig_t              sin_c;
    trig_t              cpad_reg [CORDIC_LAT+1:ST_U];
    trig_t              spad_reg [CORDIC_LAT+1:ST_U];
    unit_t              u [0:2];
    logic signed [31:0] uu_reg  [0:2][0:2];
    logic signed [33:0] us_reg  [0:2];
    logic signed [33:0] us2_reg [0:2];
    logic signed [34:0] t_reg;
    trig_t              c1_reg;
    trig_t              c2_reg;
    logic signed [33:0] tuu_reg [0:2][0:2];
    logic signed [31:0] mx_reg  [0:2][0:2];
    logic signed [63:0] prod_reg [0:2][0:2];
    logic signed [31:0] rot_reg [0:2];
    logic               sat_reg;
    logic signed [35:0] m_sum [0:2][0:2];
    logic signed [37:0] acc [0:2];
    logic [2:0]         over;

    assign adv           = !vld_reg[PIPE_LAT] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = vld_reg[PIPE_LAT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[PIPE_LAT-1:1], s_axis_tvalid};
        end
    end

    vra_cordic u_cordic (
        .aclk    (aclk),
        .en      (adv),
        .angle   (s_axis_tdata[223:192]),
        .cos_q30 (cos_c),
        .sin_q30 (sin_c)
    );

    vra_axis u_axis (
        .aclk   (aclk),
        .en     (adv),
        .axis_x (s_axis_tdata[127:96]),
        .axis_y (s_axis_tdata[159:128]),
        .axis_z (s_axis_tdata[191:160]),
        .u_x    (u[0]),
        .u_y    (u[1]),
        .u_z    (u[2])
    );

    // Vector and zero-angle flag ride alongside the arithmetic, and cosine and sine are padded to meet the axis.
    always_ff @(posedge aclk) begin
        if (adv) begin
            vd_reg[1] <= s_axis_tdata[95:0];
            za_reg[1] <= (s_axis_tdata[223:192] == '0);
            cpad_reg[CORDIC_LAT+1] <= cos_c;
            spad_reg[CORDIC_LAT+1] <= sin_c;
        end
    end

    for (genvar s = 2; s <= ST_M4; s++) begin : g_vd
        always_ff @(posedge aclk) begin
            if (adv) begin
                vd_reg[s] <= vd_reg[s-1];
                za_reg[s] <= za_reg[s-1];
            end
        end
    end

    for (genvar s = CORDIC_LAT + 2; s <= ST_U; s++) begin : g_pad
        always_ff @(posedge aclk) begin
            if (adv) begin
                cpad_reg[s] <= cpad_reg[s-1];
                spad_reg[s] <= spad_reg[s-1];
            end
        end
    end

    // First matrix stages: axis outer products, axis times sine and 1 - cos, then outer products times 1 - cos.
    for (genvar i = 0; i < 3; i++) begin : g_m1
        for (genvar j = 0; j < 3; j++) begin : g_m1j
            always_ff @(posedge aclk) begin
                if (adv) begin
                    uu_reg[i][j] <= 32'(rnd30(68'(u[i] * u[j])));
                    tuu_reg[i][j] <= 34'(rnd30(68'(t_reg * uu_reg[i][j])));
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (adv) begin
                us_reg[i]  <= 34'(rnd30(68'(u[i] * spad_reg[ST_U])));
                us2_reg[i] <= us_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            t_reg  <= Q30_ONE_T - 35'(cpad_reg[ST_U]);
            c1_reg <= cpad_reg[ST_U];
            c2_reg <= c1_reg;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                m_sum[i][j] = 36'(tuu_reg[i][j]);
            end
            m_sum[i][i] = 36'(tuu_reg[i][i]) + 36'(c2_reg);
        end
        m_sum[0][1] = 36'(tuu_reg[0][1]) - 36'(us2_reg[2]);
        m_sum[1][0] = 36'(tuu_reg[1][0]) + 36'(us2_reg[2]);
        m_sum[0][2] = 36'(tuu_reg[0][2]) + 36'(us2_reg[1]);
        m_sum[2][0] = 36'(tuu_reg[2][0]) - 36'(us2_reg[1]);
        m_sum[1][2] = 36'(tuu_reg[1][2]) - 36'(us2_reg[0]);
        m_sum[2][1] = 36'(tuu_reg[2][1]) + 36'(us2_reg[0]);
    end

    for (genvar i = 0; i < 3; i++) begin : g_m3
        for (genvar j = 0; j < 3; j++) begin : g_m3j
            always_ff @(posedge aclk) begin
                if (adv) begin
                    if (m_sum[i][j] > Q30_ONE_M) begin
                        mx_reg[i][j] <= 32'(Q30_ONE_M);
                    end else if (m_sum[i][j] < Q30_NEG_ONE_M) begin
                        mx_reg[i][j] <= 32'(Q30_NEG_ONE_M);
                    end else begin
                        mx_reg[i][j] <= m_sum[i][j][31:0];
                    end
                    prod_reg[i][j] <= mx_reg[i][j] * signed'(vd_reg[ST_M3][32*j +: 32]);
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            acc[i]  = rnd30(68'(prod_reg[i][0]) + 68'(prod_reg[i][1]) + 68'(prod_reg[i][2]));
            over[i] = (acc[i] > 38'sd2147483647) || (acc[i] < -38'sd2147483648);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                if (za_reg[ST_M4]) begin
                    rot_reg[i] <= vd_reg[ST_M4][32*i +: 32];
                end else if (acc[i] > 38'sd2147483647) begin
                    rot_reg[i] <= 32'sh7FFFFFFF;
                end else if (acc[i] < -38'sd2147483648) begin
                    rot_reg[i] <= 32'sh80000000;
                end else begin
                    rot_reg[i] <= acc[i][31:0];
                end
            end
            sat_reg <= !za_reg[ST_M4] && (over != '0);
        end
    end

    assign m_axis_tdata = {rot_reg[2], rot_reg[1], rot_reg[0]};
    assign m_axis_tuser = sat_reg;

endmodule
